### rtl/dls_pkg.sv
// ----------------------------------------------------------------------------
// dls_pkg
// Shared types and constants for the decimal line summer: byte classes,
// the token passed from the front end to the execution unit, status codes.
// ----------------------------------------------------------------------------
package dls_pkg;

  localparam int SUM_BITS    = 64;
  localparam int TOTAL_W     = 64;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int DIGIT_W     = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NUM_OVF  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SUM_OVF  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CHAR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_END  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_INPUT = 3'd5;

  typedef enum logic [2:0] {
    K_NUL   = 3'd0,
    K_LF    = 3'd1,
    K_CR    = 3'd2,
    K_SPACE = 3'd3,
    K_DIGIT = 3'd4,
    K_BAD   = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [DIGIT_W-1:0]  digit;
  } token_t;

endpackage

### rtl/dls_front.sv
// ----------------------------------------------------------------------------
// dls_front
// Input handshake and byte classification. Each accepted byte becomes one
// token for the queue.
// ----------------------------------------------------------------------------
module dls_front (
  input  logic                         byte_valid,
  output logic                         byte_ready,
  input  logic [dls_pkg::BYTE_W-1:0]   byte_req,
  input  logic                         q_ready,
  output logic                         push,
  output dls_pkg::token_t              tok
);
  import dls_pkg::*;

  assign byte_ready = q_ready;
  assign push       = byte_valid && q_ready;

  always_comb begin
    tok.digit = byte_req[DIGIT_W-1:0];
    case (byte_req) inside
      CHAR_NUL:               tok.kind = K_NUL;
      CHAR_LF:                tok.kind = K_LF;
      CHAR_CR:                tok.kind = K_CR;
      CHAR_SPACE:             tok.kind = K_SPACE;
      [CHAR_ZERO:CHAR_NINE]:  tok.kind = K_DIGIT;
      default:                tok.kind = K_BAD;
    endcase
  end

endmodule

### rtl/dls_queue.sv
// ----------------------------------------------------------------------------
// dls_queue
// Short token queue between the front end and the execution unit.
// ----------------------------------------------------------------------------
module dls_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  dls_pkg::token_t               push_tok,
  output logic                          q_ready,
  input  logic                          pop,
  output logic                          tok_valid,
  output dls_pkg::token_t               head_tok,
  output logic [dls_pkg::QCNT_W-1:0]    count
);
  import dls_pkg::*;

  token_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;

  assign q_ready   = (count != QCNT_W'(QUEUE_DEPTH));
  assign tok_valid = (count != '0);
  assign head_tok  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/dls_back.sv
// ----------------------------------------------------------------------------
// dls_back
// Execution unit. Runs the line parser on one token per cycle unless a result
// waits on a stalled output, builds the current number and the running sum, and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module dls_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tok_valid,
  input  dls_pkg::token_t                tok,
  output logic                           pop,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [dls_pkg::STATUS_W-1:0]   status_code,
  output logic [dls_pkg::TOTAL_W-1:0]    total
);
  import dls_pkg::*;

  localparam logic [1:0] PH_SCAN = 2'd0;
  localparam logic [1:0] PH_CR   = 2'd1;
  localparam logic [1:0] PH_DROP = 2'd2;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_NUM  = 2'd1;
  localparam logic [1:0] ERR_SUM  = 2'd2;

  logic [1:0]           phase;
  logic [1:0]           phase_next;
  logic [SUM_BITS-1:0]  running_sum;
  logic [SUM_BITS-1:0]  running_sum_next;
  logic [SUM_BITS-1:0]  current_number;
  logic [SUM_BITS-1:0]  current_number_next;
  logic                 number_too_big;
  logic                 number_too_big_next;
  logic [1:0]           first_err;
  logic [1:0]           first_err_next;
  logic                 seen_digit;
  logic                 seen_digit_next;

  logic [SUM_BITS:0]    field_add;
  logic [SUM_BITS+3:0]  digit_acc;
  logic [1:0]           err_closed;
  logic [SUM_BITS-1:0]  sum_closed;
  logic [STATUS_W-1:0]  line_code;
  logic [STATUS_W-1:0]  emit_code;
  logic                 emit;
  logic                 clear_line;
  logic                 close_field;
  logic                 can_emit;

  always_comb begin
    field_add  = {1'b0, running_sum} + {1'b0, current_number};
    digit_acc  = ({4'b0, current_number} << 3) + ({4'b0, current_number} << 1)
               + (SUM_BITS + 4)'(tok.digit);
    err_closed = first_err;
    sum_closed = running_sum;
    if (first_err == ERR_NONE) begin
      if (number_too_big) begin
        err_closed = ERR_NUM;
      end else if (field_add[SUM_BITS]) begin
        err_closed = ERR_SUM;
      end else begin
        sum_closed = field_add[SUM_BITS-1:0];
      end
    end
    if (!seen_digit) begin
      line_code = ST_NO_INPUT;
    end else if (err_closed == ERR_NUM) begin
      line_code = ST_NUM_OVF;
    end else if (err_closed == ERR_SUM) begin
      line_code = ST_SUM_OVF;
    end else begin
      line_code = ST_OK;
    end
  end

  always_comb begin
    phase_next  = phase;
    emit        = 1'b0;
    emit_code   = ST_OK;
    clear_line  = 1'b0;
    close_field = 1'b0;
    case (phase)
      PH_CR: begin
        emit = 1'b1;
        if (tok.kind == K_LF) begin
          emit_code   = line_code;
          close_field = 1'b1;
          phase_next  = PH_DROP;
        end else if (tok.kind == K_NUL) begin
          emit_code  = ST_BAD_END;
          phase_next = PH_SCAN;
          clear_line = 1'b1;
        end else begin
          emit_code  = ST_BAD_END;
          phase_next = PH_DROP;
        end
      end
      PH_SCAN: begin
        case (tok.kind)
          K_NUL: begin
            emit       = 1'b1;
            emit_code  = line_code;
            clear_line = 1'b1;
          end
          K_LF: begin
            emit        = 1'b1;
            emit_code   = line_code;
            close_field = 1'b1;
            phase_next  = PH_DROP;
          end
          K_CR: begin
            phase_next = PH_CR;
          end
          K_SPACE: begin
            close_field = 1'b1;
          end
          K_DIGIT: begin
          end
          default: begin
            emit       = 1'b1;
            emit_code  = ST_BAD_CHAR;
            phase_next = PH_DROP;
          end
        endcase
      end
      default: begin
        if (tok.kind == K_NUL) begin
          phase_next = PH_SCAN;
          clear_line = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    running_sum_next    = running_sum;
    current_number_next = current_number;
    number_too_big_next = number_too_big;
    first_err_next      = first_err;
    seen_digit_next     = seen_digit;
    if (clear_line) begin
      running_sum_next    = '0;
      current_number_next = '0;
      number_too_big_next = 1'b0;
      first_err_next      = ERR_NONE;
      seen_digit_next     = 1'b0;
    end else if (close_field) begin
      running_sum_next    = sum_closed;
      first_err_next      = err_closed;
      current_number_next = '0;
      number_too_big_next = 1'b0;
    end else if (phase == PH_SCAN && tok.kind == K_DIGIT) begin
      seen_digit_next = 1'b1;
      if (!number_too_big) begin
        if (digit_acc[SUM_BITS+3:SUM_BITS] != 4'b0) begin
          number_too_big_next = 1'b1;
        end else begin
          current_number_next = digit_acc[SUM_BITS-1:0];
        end
      end
    end
  end

  assign can_emit = !result_valid || result_ready;
  assign pop      = tok_valid && (!emit || can_emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCAN;
      running_sum    <= '0;
      current_number <= '0;
      number_too_big <= 1'b0;
      first_err      <= ERR_NONE;
      seen_digit     <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      running_sum    <= running_sum_next;
      current_number <= current_number_next;
      number_too_big <= number_too_big_next;
      first_err      <= first_err_next;
      seen_digit     <= seen_digit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      status_code <= emit_code;
      total       <= (emit_code == ST_OK) ? TOTAL_W'(sum_closed) : '0;
    end
  end

endmodule

### rtl/decimal_line_summer.sv
// ----------------------------------------------------------------------------
// decimal_line_summer
// Sums a line of space-separated ASCII decimal numbers, one byte per item,
// and reports one status and total per buffer line.
//
//   Channel   Handshake                    Payload
//   input     byte_valid / byte_ready      byte_req
//   output    result_valid / result_ready  status_code, total
//
// One byte is taken per cycle while the queue has room; the execution unit
// retires one token per cycle, paced by its multiply-by-ten add and sum add,
// unless a result waits on a stalled output. An accepted byte waits in a queue
// slot until popped, and its result is registered. A stalled output holds the
// queue only at a byte that produces a result; the queue keeps taking bytes
// until its four entries fill. Reset clears the queue, parser and result_valid.
// ----------------------------------------------------------------------------
module decimal_line_summer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           byte_valid,
  output logic                           byte_ready,
  input  logic [dls_pkg::BYTE_W-1:0]     byte_req,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [dls_pkg::STATUS_W-1:0]   status_code,
  output logic [dls_pkg::TOTAL_W-1:0]    total
);
  import dls_pkg::*;

  logic                push;
  logic                q_ready;
  logic                pop;
  logic                tok_valid;
  token_t              push_tok;
  token_t              head_tok;
  logic [QCNT_W-1:0]   q_count;

  dls_front u_front (
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_req   (byte_req),
    .q_ready    (q_ready),
    .push       (push),
    .tok        (push_tok)
  );

  dls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_tok  (push_tok),
    .q_ready   (q_ready),
    .pop       (pop),
    .tok_valid (tok_valid),
    .head_tok  (head_tok),
    .count     (q_count)
  );

  dls_back u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (tok_valid),
    .tok          (head_tok),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status_code  (status_code),
    .total        (total)
  );

  a_err_total_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status_code != ST_OK |-> total == '0)
    else $error("Error result carries a nonzero total.");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> status_code <= ST_NO_INPUT)
    else $error("Status code out of range.");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_count != '0)
    else $error("Token taken from an empty queue.");

  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !byte_ready |-> q_count == QCNT_W'(QUEUE_DEPTH))
    else $error("Input stalled while the queue has room.");

endmodule
